// File: sv/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// Shared sizes, codes and controller/datapath interface types for the
// positional list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ple_pkg;

   localparam int CAPACITY = 16;

   localparam int CMD_W  = 2;
   localparam int POS_W  = 8;
   localparam int VAL_W  = 32;
   localparam int STAT_W = 2;
   localparam int LEN_W  = 5;

   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int IDX_W  = $clog2(CAPACITY);
   localparam int REM_W  = CNT_W + 1;
   localparam int CMP_W  = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;
   localparam int MCNT_W = $clog2(POS_W + 1);

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 1;
   localparam logic [REG_IDX_W-1:0] REG_WRAP_MODE = '0;

   typedef enum logic [CMD_W-1:0] {
      CMD_APPEND = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_DELETE = 2'd2,
      CMD_DUMP   = 2'd3
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_EMPTY = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_MOD,
      S_SETUP,
      S_SHIFT,
      S_DRAIN,
      S_COMMIT,
      S_RESP,
      S_DUMP_RD,
      S_DUMP_OUT
   } state_type;

   typedef struct packed {
      logic       load;
      logic       mod_start;
      logic       mod_step;
      logic       pos_from_rem;
      logic       idx_init;
      logic       idx_zero;
      logic       shift_step;
      logic       dump_read;
      logic       commit;
      logic       rsp_load;
      logic       rsp_entry;
      logic       rsp_last;
      status_type rsp_status;
   } ctl_type;

   typedef struct packed {
      cmd_type cmd;
      logic    wrap;
      logic    full;
      logic    empty;
      logic    pos_gt_count;
      logic    pos_lt_count;
      logic    mod_done;
      logic    shift_more;
      logic    dump_last;
      logic    rsp_free;
   } flag_type;

endpackage

`default_nettype wire

// File: sv/ple_ctrl.sv
// ----------------------------------------------------------------------------
// ple_ctrl
// Command sequencer: decodes each transaction, runs the modulo and shift
// phases and hands results to the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire ple_pkg::flag_type flags,
   output ple_pkg::ctl_type       ctl
);

   ple_pkg::state_type  state_ff;
   ple_pkg::state_type  state_in;
   ple_pkg::status_type status_ff;
   ple_pkg::status_type status_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ple_pkg::S_IDLE;
         status_ff <= ple_pkg::ST_OK;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
      end
   end

   assign req_stall = (state_ff != ple_pkg::S_IDLE);

   always_comb begin
      state_in       = state_ff;
      status_in      = status_ff;
      ctl            = '0;
      ctl.rsp_status = status_ff;
      case (state_ff)
         ple_pkg::S_IDLE: begin
            if (req_valid) begin
               ctl.load = 1'b1;
               state_in = ple_pkg::S_DECODE;
            end
         end
         ple_pkg::S_DECODE: begin
            case (flags.cmd)
               ple_pkg::CMD_APPEND: begin
                  state_in = ple_pkg::S_RESP;
                  if (flags.full) begin
                     status_in = ple_pkg::ST_FULL;
                  end else begin
                     ctl.commit = 1'b1;
                     status_in  = ple_pkg::ST_OK;
                  end
               end
               ple_pkg::CMD_INSERT: begin
                  if (!flags.wrap && flags.pos_gt_count) begin
                     status_in = ple_pkg::ST_RANGE;
                     state_in  = ple_pkg::S_RESP;
                  end else if (flags.full) begin
                     status_in = ple_pkg::ST_FULL;
                     state_in  = ple_pkg::S_RESP;
                  end else if (flags.wrap) begin
                     ctl.mod_start = 1'b1;
                     state_in      = ple_pkg::S_MOD;
                  end else begin
                     state_in = ple_pkg::S_SETUP;
                  end
               end
               ple_pkg::CMD_DELETE: begin
                  if (flags.empty) begin
                     status_in = ple_pkg::ST_EMPTY;
                     state_in  = ple_pkg::S_RESP;
                  end else if (!flags.wrap && !flags.pos_lt_count) begin
                     status_in = ple_pkg::ST_RANGE;
                     state_in  = ple_pkg::S_RESP;
                  end else if (flags.wrap) begin
                     ctl.mod_start = 1'b1;
                     state_in      = ple_pkg::S_MOD;
                  end else begin
                     state_in = ple_pkg::S_SETUP;
                  end
               end
               ple_pkg::CMD_DUMP: begin
                  if (flags.empty) begin
                     status_in = ple_pkg::ST_EMPTY;
                     state_in  = ple_pkg::S_RESP;
                  end else begin
                     ctl.idx_zero = 1'b1;
                     state_in     = ple_pkg::S_DUMP_RD;
                  end
               end
               default: state_in = ple_pkg::S_IDLE;
            endcase
         end
         ple_pkg::S_MOD: begin
            if (flags.mod_done) begin
               ctl.pos_from_rem = 1'b1;
               state_in         = ple_pkg::S_SETUP;
            end else begin
               ctl.mod_step = 1'b1;
            end
         end
         ple_pkg::S_SETUP: begin
            ctl.idx_init = 1'b1;
            state_in     = ple_pkg::S_SHIFT;
         end
         ple_pkg::S_SHIFT: begin
            if (flags.shift_more) begin
               ctl.shift_step = 1'b1;
            end else begin
               state_in = ple_pkg::S_DRAIN;
            end
         end
         ple_pkg::S_DRAIN: begin
            state_in = ple_pkg::S_COMMIT;
         end
         ple_pkg::S_COMMIT: begin
            ctl.commit = 1'b1;
            status_in  = ple_pkg::ST_OK;
            state_in   = ple_pkg::S_RESP;
         end
         ple_pkg::S_RESP: begin
            if (flags.rsp_free) begin
               ctl.rsp_load = 1'b1;
               ctl.rsp_last = 1'b1;
               state_in     = ple_pkg::S_IDLE;
            end
         end
         ple_pkg::S_DUMP_RD: begin
            ctl.dump_read = 1'b1;
            state_in      = ple_pkg::S_DUMP_OUT;
         end
         ple_pkg::S_DUMP_OUT: begin
            ctl.rsp_status = ple_pkg::ST_OK;
            if (flags.rsp_free) begin
               ctl.rsp_load  = 1'b1;
               ctl.rsp_entry = 1'b1;
               ctl.rsp_last  = flags.dump_last;
               state_in      = flags.dump_last ? ple_pkg::S_IDLE : ple_pkg::S_DUMP_RD;
            end
         end
         default: state_in = ple_pkg::S_IDLE;
      endcase
   end

endmodule

`default_nettype wire

// File: sv/ple_dp.sv
// ----------------------------------------------------------------------------
// ple_dp
// Datapath: entry memory, count, bit-serial modulo, shift pipeline,
// mode register and response register.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_dp (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire ple_pkg::ctl_type                     ctl,
   output ple_pkg::flag_type                         flags,
   input  wire logic [ple_pkg::CMD_W-1:0]            req_command,
   input  wire logic [ple_pkg::POS_W-1:0]            req_position,
   input  wire logic signed [ple_pkg::VAL_W-1:0]     req_value,
   input  wire logic                                 wrap_we,
   input  wire logic                                 wrap_wdata,
   output logic                                      wrap_mode,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [ple_pkg::STAT_W-1:0]                rsp_status,
   output logic signed [ple_pkg::VAL_W-1:0]          rsp_entry_value,
   output logic [ple_pkg::LEN_W-1:0]                 rsp_list_length,
   output logic                                      rsp_last
);

   localparam int CNT_W = ple_pkg::CNT_W;
   localparam int IDX_W = ple_pkg::IDX_W;
   localparam int POS_W = ple_pkg::POS_W;
   localparam int VAL_W = ple_pkg::VAL_W;
   localparam int REM_W = ple_pkg::REM_W;
   localparam int CMP_W = ple_pkg::CMP_W;
   localparam int MCNT_W = ple_pkg::MCNT_W;

   logic signed [VAL_W-1:0] entry_store_ff [ple_pkg::CAPACITY];

   ple_pkg::cmd_type        cmd_ff, cmd_in;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic signed [VAL_W-1:0] val_ff, val_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    wrap_ff, wrap_in;
   logic [CNT_W-1:0]        idx_ff, idx_in;
   logic [REM_W-1:0]        rem_ff, rem_in;
   logic [MCNT_W-1:0]       mcnt_ff, mcnt_in;
   logic                    wr_pend_ff, wr_pend_in;
   logic [IDX_W-1:0]        wr_addr_ff, wr_addr_in;
   logic signed [VAL_W-1:0] rd_data_ff;

   logic                           rsp_valid_ff, rsp_valid_in;
   ple_pkg::status_type            rsp_status_ff, rsp_status_in;
   logic signed [VAL_W-1:0]        rsp_entry_ff, rsp_entry_in;
   logic [ple_pkg::LEN_W-1:0]      rsp_len_ff, rsp_len_in;
   logic                           rsp_last_ff, rsp_last_in;

   logic [REM_W-1:0]        divisor;
   logic [REM_W-1:0]        shifted;
   logic [REM_W-1:0]        rem_next;
   logic                    is_insert;
   logic                    is_delete;
   logic [CNT_W-1:0]        idx_dec;
   logic [CNT_W-1:0]        idx_inc;
   logic                    rd_en;
   logic [IDX_W-1:0]        rd_addr;
   logic                    wr_en;
   logic [IDX_W-1:0]        wr_addr;
   logic signed [VAL_W-1:0] wr_data;

   assign is_insert = (cmd_ff == ple_pkg::CMD_INSERT);
   assign is_delete = (cmd_ff == ple_pkg::CMD_DELETE);
   assign idx_dec   = idx_ff - CNT_W'(1);
   assign idx_inc   = idx_ff + CNT_W'(1);

   // restoring modulo, one dividend bit per step
   assign divisor  = is_insert ? ({1'b0, count_ff} + REM_W'(1)) : {1'b0, count_ff};
   assign shifted  = {rem_ff[REM_W-2:0], pos_ff[POS_W-1]};
   assign rem_next = (shifted >= divisor) ? (shifted - divisor) : shifted;

   always_comb begin
      flags.cmd          = cmd_ff;
      flags.wrap         = wrap_ff;
      flags.full         = (count_ff == CNT_W'(ple_pkg::CAPACITY));
      flags.empty        = (count_ff == '0);
      flags.pos_gt_count = (CMP_W'(pos_ff) > CMP_W'(count_ff));
      flags.pos_lt_count = (CMP_W'(pos_ff) < CMP_W'(count_ff));
      flags.mod_done     = (mcnt_ff == MCNT_W'(POS_W));
      flags.shift_more   = is_insert ? (CMP_W'(idx_ff) > CMP_W'(pos_ff))
                                     : ((CMP_W'(idx_ff) + CMP_W'(1)) < CMP_W'(count_ff));
      flags.dump_last    = (idx_ff == count_ff);
      flags.rsp_free     = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      cmd_in     = ctl.load ? ple_pkg::cmd_type'(req_command) : cmd_ff;
      val_in     = ctl.load ? req_value : val_ff;
      wrap_in    = wrap_we ? wrap_wdata : wrap_ff;
      pos_in     = pos_ff;
      rem_in     = rem_ff;
      mcnt_in    = mcnt_ff;
      idx_in     = idx_ff;
      count_in   = count_ff;
      wr_pend_in = ctl.shift_step;
      wr_addr_in = idx_ff[IDX_W-1:0];
      if (ctl.load) begin
         pos_in = req_position;
      end else if (ctl.mod_step) begin
         pos_in = {pos_ff[POS_W-2:0], 1'b0};
      end else if (ctl.pos_from_rem) begin
         pos_in = POS_W'(rem_ff);
      end
      if (ctl.mod_start) begin
         rem_in  = '0;
         mcnt_in = '0;
      end else if (ctl.mod_step) begin
         rem_in  = rem_next;
         mcnt_in = mcnt_ff + MCNT_W'(1);
      end
      if (ctl.idx_init) begin
         idx_in = is_insert ? count_ff : CNT_W'(pos_ff);
      end else if (ctl.idx_zero) begin
         idx_in = '0;
      end else if (ctl.shift_step) begin
         idx_in = is_insert ? idx_dec : idx_inc;
      end else if (ctl.dump_read) begin
         idx_in = idx_inc;
      end
      if (ctl.commit) begin
         count_in = is_delete ? (count_ff - CNT_W'(1)) : (count_ff + CNT_W'(1));
      end
   end

   // memory ports
   always_comb begin
      rd_en   = ctl.shift_step || ctl.dump_read;
      rd_addr = idx_ff[IDX_W-1:0];
      if (ctl.shift_step) begin
         rd_addr = is_insert ? idx_dec[IDX_W-1:0] : idx_inc[IDX_W-1:0];
      end
      wr_en   = 1'b0;
      wr_addr = wr_addr_ff;
      wr_data = rd_data_ff;
      if (wr_pend_ff) begin
         wr_en = 1'b1;
      end else if (ctl.commit && !is_delete) begin
         wr_en   = 1'b1;
         wr_addr = is_insert ? IDX_W'(pos_ff) : IDX_W'(count_ff);
         wr_data = val_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= entry_store_ff[rd_addr];
      end
      if (wr_en) begin
         entry_store_ff[wr_addr] <= wr_data;
      end
   end

   always_comb begin
      rsp_valid_in  = ctl.rsp_load ? 1'b1 : (rsp_valid_ff && rsp_stall);
      rsp_status_in = rsp_status_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_last_in   = rsp_last_ff;
      if (ctl.rsp_load) begin
         rsp_status_in = ctl.rsp_status;
         rsp_entry_in  = ctl.rsp_entry ? rd_data_ff : '0;
         rsp_len_in    = ple_pkg::LEN_W'(count_ff);
         rsp_last_in   = ctl.rsp_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         wrap_ff      <= 1'b1;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         wrap_ff      <= wrap_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      idx_ff        <= idx_in;
      rem_ff        <= rem_in;
      mcnt_ff       <= mcnt_in;
      wr_addr_ff    <= wr_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign wrap_mode       = wrap_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_value = rsp_entry_ff;
   assign rsp_list_length = rsp_len_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

`default_nettype wire

// File: sv/positional_list_engine.sv
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of signed 32-bit values with append, insert, delete and dump
// commands, a wrap-mode register and a registered result channel.
// ----------------------------------------------------------------------------
// One transaction at a time. Append and every flagged command go from decode
// straight to the result state, which loads the output register. Insert and
// delete also move entries, and the entry memory takes one read and one write
// per cycle and so moves one entry per cycle; wrap mode adds a bit-serial
// modulo of the position first. Dump reads each entry from memory, then loads
// it into the output register. A stalled result delays the next result by the
// stall time; a new request is taken once the previous result is in the output
// register.
`default_nettype none

module positional_list_engine (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [ple_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  wire logic [ple_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [ple_pkg::CSR_DATA_W-1:0]            csr_prdata,
   output logic                                      csr_pready,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [ple_pkg::CMD_W-1:0]            req_command,
   input  wire logic [ple_pkg::POS_W-1:0]            req_position,
   input  wire logic signed [ple_pkg::VAL_W-1:0]     req_value,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [ple_pkg::STAT_W-1:0]                rsp_status,
   output logic signed [ple_pkg::VAL_W-1:0]          rsp_entry_value,
   output logic [ple_pkg::LEN_W-1:0]                 rsp_list_length,
   output logic                                      rsp_last
);

   ple_pkg::ctl_type                  ctl;
   ple_pkg::flag_type                 flags;
   logic [ple_pkg::REG_IDX_W-1:0]     reg_idx;
   logic                              wrap_we;
   logic                              wrap_mode;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[ple_pkg::CSR_ADDR_W-1:2];
   assign wrap_we    = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (reg_idx == ple_pkg::REG_WRAP_MODE);
   assign csr_prdata = (reg_idx == ple_pkg::REG_WRAP_MODE)
                       ? {{(ple_pkg::CSR_DATA_W-1){1'b0}}, wrap_mode} : '0;

   ple_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .flags     (flags),
      .ctl       (ctl)
   );

   ple_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .flags           (flags),
      .req_command     (req_command),
      .req_position    (req_position),
      .req_value       (req_value),
      .wrap_we         (wrap_we),
      .wrap_wdata      (csr_pwdata[0]),
      .wrap_mode       (wrap_mode),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_entry_value (rsp_entry_value),
      .rsp_list_length (rsp_list_length),
      .rsp_last        (rsp_last)
   );

`ifndef SYNTHESIS
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (int'(rsp_list_length) <= ple_pkg::CAPACITY))
      else $error("list length above capacity");

   a_error_zero_entry: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ple_pkg::ST_OK)) |-> (rsp_entry_value == '0))
      else $error("error result carries an entry value");

   a_partial_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> (rsp_status == ple_pkg::ST_OK))
      else $error("non-final result with error status");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while a transaction is in progress");
`endif

endmodule

`default_nettype wire

// File: tb/sv/positional_list_engine_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_engine_checker
// Passive monitor for the positional list engine. Tracks register writes and
// accepted commands and keeps its own copy of the list and the wrap mode. It
// queues the result transactions each command should produce and compares
// every accepted result against the oldest one.
// ----------------------------------------------------------------------------
module positional_list_engine_checker
   import ple_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0]         csr_paddr,
   input  wire logic [CSR_DATA_W-1:0]         csr_pwdata,
   input  wire logic                          csr_pready,
   input  wire logic                          req_valid,
   input  wire logic                          req_stall,
   input  wire logic [CMD_W-1:0]              req_command,
   input  wire logic [POS_W-1:0]              req_position,
   input  wire logic signed [VAL_W-1:0]       req_value,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   input  wire logic [STAT_W-1:0]             rsp_status,
   input  wire logic signed [VAL_W-1:0]       rsp_entry_value,
   input  wire logic [LEN_W-1:0]              rsp_list_length,
   input  wire logic                          rsp_last,
   output int                                 mismatch_count,
   output int                                 outstanding
);

   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      status_type              status;
      logic signed [VAL_W-1:0] entry_value;
      logic [LEN_W-1:0]        list_length;
      logic                    last;
   } list_result_type;

   list_result_type         expected_results[$];
   logic signed [VAL_W-1:0] list_entries[CAPACITY];
   int                      list_count;
   logic                    wrap_enable;

   task automatic push_result(input status_type st, input logic signed [VAL_W-1:0] v,
                              input logic is_last);
      list_result_type item;
      item.status      = st;
      item.entry_value = v;
      item.list_length = LEN_W'(list_count);
      item.last        = is_last;
      expected_results.push_back(item);
   endtask

   task automatic apply_command(input cmd_type cmd, input int pos,
                                input logic signed [VAL_W-1:0] val);
      int slot;
      int i;
      slot = pos;
      case (cmd)
         CMD_APPEND: begin
            if (list_count >= CAPACITY) begin
               push_result(ST_FULL, '0, 1'b1);
            end else begin
               list_entries[list_count] = val;
               list_count++;
               push_result(ST_OK, '0, 1'b1);
            end
         end
         CMD_INSERT: begin
            if (wrap_enable) slot = pos % (list_count + 1);
            if (!wrap_enable && pos > list_count) begin
               push_result(ST_RANGE, '0, 1'b1);
            end else if (list_count >= CAPACITY) begin
               push_result(ST_FULL, '0, 1'b1);
            end else begin
               for (i = list_count; i > slot; i--) list_entries[i] = list_entries[i-1];
               list_entries[slot] = val;
               list_count++;
               push_result(ST_OK, '0, 1'b1);
            end
         end
         CMD_DELETE: begin
            if (list_count == 0) begin
               push_result(ST_EMPTY, '0, 1'b1);
            end else begin
               if (wrap_enable) slot = pos % list_count;
               if (!wrap_enable && pos >= list_count) begin
                  push_result(ST_RANGE, '0, 1'b1);
               end else begin
                  for (i = slot; i + 1 < list_count; i++) list_entries[i] = list_entries[i+1];
                  list_count--;
                  push_result(ST_OK, '0, 1'b1);
               end
            end
         end
         default: begin
            if (list_count == 0) begin
               push_result(ST_EMPTY, '0, 1'b1);
            end else begin
               for (i = 0; i < list_count; i++)
                  push_result(ST_OK, list_entries[i], i + 1 == list_count);
            end
         end
      endcase
   endtask

   task automatic report_failure(input string msg);
      if (mismatch_count < MAX_REPORTS) $display("%0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      list_result_type oldest;
      if (reset) begin
         list_count  = 0;
         wrap_enable = 1'b1;
         expected_results.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[CSR_ADDR_W-1:2] == REG_WRAP_MODE)
            wrap_enable = csr_pwdata[0];
         if (req_valid && !req_stall)
            apply_command(cmd_type'(req_command), int'(req_position), req_value);
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report_failure($sformatf({"unexpected result: status %0d value %0d ",
                                         "length %0d last %0d"},
                                        rsp_status, rsp_entry_value, rsp_list_length,
                                        rsp_last));
            end else begin
               oldest = expected_results.pop_front();
               if (rsp_status !== oldest.status || rsp_entry_value !== oldest.entry_value ||
                   rsp_list_length !== oldest.list_length || rsp_last !== oldest.last)
                  report_failure($sformatf({"result mismatch (expected/actual): status %0d/%0d ",
                                            "value %0d/%0d length %0d/%0d last %0d/%0d"},
                                           oldest.status, rsp_status,
                                           oldest.entry_value, rsp_entry_value,
                                           oldest.list_length, rsp_list_length,
                                           oldest.last, rsp_last));
            end
         end
      end
      outstanding = expected_results.size();
   end

endmodule

// File: tb/sv/positional_list_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_engine_tb
// Drives the positional list engine with a directed pass over the range,
// empty and full cases in both wrap modes, then random command streams that
// fill and drain the list under both wrap settings. Both channels idle at
// random, and one long receiver hold-off backs the block up. The checker
// beside the block predicts and compares every result transaction.
// ----------------------------------------------------------------------------
module positional_list_engine_tb;
   import ple_pkg::*;

   localparam int LIMIT_NS      = 5_000_000;
   localparam int SETTLE_CYCLES = 40;
   localparam int LONG_HOLD     = 200;
   localparam logic [CSR_ADDR_W-1:0] ADDR_WRAP_MODE = CSR_ADDR_W'(4 * REG_WRAP_MODE);
   localparam logic [CSR_ADDR_W-1:0] ADDR_SPARE     = CSR_ADDR_W'(4);
   localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    csr_psel;
   logic                    csr_penable;
   logic                    csr_pwrite;
   logic [CSR_ADDR_W-1:0]   csr_paddr;
   logic [CSR_DATA_W-1:0]   csr_pwdata;
   logic [CSR_DATA_W-1:0]   csr_prdata;
   logic                    csr_pready;
   logic                    req_valid;
   logic                    req_stall;
   logic [CMD_W-1:0]        req_command;
   logic [POS_W-1:0]        req_position;
   logic signed [VAL_W-1:0] req_value;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic [STAT_W-1:0]       rsp_status;
   logic signed [VAL_W-1:0] rsp_entry_value;
   logic [LEN_W-1:0]        rsp_list_length;
   logic                    rsp_last;
   int                      mismatch_count;
   int                      outstanding;
   bit                      sender_gaps = 1'b1;
   bit                      hold_request = 1'b0;

   positional_list_engine dut (.*);

   positional_list_engine_checker checker_inst (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic send_item(input cmd_type cmd, input logic [POS_W-1:0] pos,
                            input logic signed [VAL_W-1:0] val);
      int gap;
      int r;
      gap = 0;
      if (sender_gaps) begin
         r = $urandom_range(0, 99);
         if (r >= 90) gap = $urandom_range(8, 30);
         else if (r >= 45) gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    = 1'b1;
      req_command  = cmd;
      req_position = pos;
      req_value    = val;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_ADDR_W-1:0] addr,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = addr;
      csr_pwdata  = data;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic wait_until_idle();
      req_valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic run_random(input int count, input int w_append, input int w_insert,
                             input int w_delete);
      int                      n;
      int                      r;
      cmd_type                 cmd;
      logic [POS_W-1:0]        pos;
      logic signed [VAL_W-1:0] val;
      for (n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (r < w_append) cmd = CMD_APPEND;
         else if (r < w_append + w_insert) cmd = CMD_INSERT;
         else if (r < w_append + w_insert + w_delete) cmd = CMD_DELETE;
         else cmd = CMD_DUMP;
         if ($urandom_range(0, 9) < 7) pos = POS_W'($urandom_range(0, CAPACITY + 2));
         else pos = POS_W'($urandom);
         case ($urandom_range(0, 9))
            0: val = VAL_MAX;
            1: val = VAL_MIN;
            2: val = '0;
            3: val = '1;
            default: val = $urandom;
         endcase
         send_item(cmd, pos, val);
      end
   endtask

   // receiver: random stall and run stretches, plus one long hold on request
   initial begin
      int stall_left;
      int run_left;
      int r;
      stall_left = 0;
      run_left   = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall    = 1'b1;
            repeat (LONG_HOLD) @(negedge clock);
         end
         if (stall_left == 0 && run_left == 0) begin
            r = $urandom_range(0, 99);
            if (r < 50) run_left = $urandom_range(1, 4);
            else if (r < 85) stall_left = $urandom_range(1, 3);
            else if (r < 93) stall_left = $urandom_range(10, 40);
            else run_left = $urandom_range(30, 80);
         end
         if (stall_left > 0) begin
            rsp_stall = 1'b1;
            stall_left--;
         end else begin
            rsp_stall = 1'b0;
            run_left--;
         end
      end
   end

   initial begin
      int i;
      reset        = 1'b1;
      csr_psel     = 1'b0;
      csr_penable  = 1'b0;
      csr_pwrite   = 1'b0;
      csr_paddr    = '0;
      csr_pwdata   = '0;
      req_valid    = 1'b0;
      req_command  = CMD_APPEND;
      req_position = '0;
      req_value    = '0;
      repeat (2) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // wrap mode at its reset value
      send_item(CMD_DUMP,   8'd0,   '0);
      send_item(CMD_DELETE, 8'd7,   '0);
      send_item(CMD_INSERT, 8'hFF,  VAL_MAX);
      send_item(CMD_APPEND, 8'h00,  VAL_MIN);
      send_item(CMD_INSERT, 8'd200, '1);
      send_item(CMD_APPEND, 8'hAA,  '0);
      send_item(CMD_DELETE, 8'hFF,  32'sh1234_5678);
      wait_until_idle();

      // only bit 0 counts; the spare address is ignored
      write_register(ADDR_WRAP_MODE, 32'hFFFF_FFFE);
      write_register(ADDR_SPARE, 32'h0000_0001);
      send_item(CMD_INSERT, 8'd4,   32'sh5555_5555);
      send_item(CMD_DELETE, 8'd3,   '0);
      send_item(CMD_INSERT, 8'd3,   32'sh5555_5555);
      send_item(CMD_DELETE, 8'd0,   '0);
      for (i = 0; i < CAPACITY - 3; i++) send_item(CMD_APPEND, POS_W'(i), VAL_W'(i * 7 - 40));
      send_item(CMD_APPEND, 8'd0,   VAL_MAX);
      send_item(CMD_INSERT, 8'd17,  '0);
      send_item(CMD_INSERT, 8'd16,  '0);
      send_item(CMD_DELETE, 8'd16,  '0);
      send_item(CMD_DUMP,   8'd0,   '0);
      wait_until_idle();

      write_register(ADDR_WRAP_MODE, 32'h0000_0001);
      send_item(CMD_INSERT, 8'hFF,  VAL_MIN);
      wait_until_idle();

      write_register(ADDR_WRAP_MODE, 32'h0000_0000);
      run_random(25, 15, 20, 50);
      wait_until_idle();

      write_register(ADDR_WRAP_MODE, 32'h0000_0001);
      hold_request = 1'b1;
      run_random(25, 40, 30, 10);
      wait_until_idle();

      write_register(ADDR_WRAP_MODE, 32'h0000_0000);
      sender_gaps = 1'b0;
      run_random(25, 35, 30, 20);
      wait_until_idle();

      write_register(ADDR_WRAP_MODE, 32'h0000_0001);
      sender_gaps = 1'b1;
      run_random(25, 25, 25, 35);
      wait_until_idle();

      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #LIMIT_NS;
      $display("FAIL");
      $finish;
   end

endmodule
